// File: sv/btm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// btm_pkg: shared types and constants of the metronome core
// Field widths, reset values, register indexes and the divider handshake.
// ---------------------------------------------------------------------------
package btm_pkg;

	localparam int TEMPO_W  = 9;
	localparam int PERIOD_W = 16;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [PERIOD_W-1:0] PERIOD_NUMERATOR = 16'd60000;
	localparam logic [TEMPO_W-1:0]  TEMPO_RESET      = 9'd120;
	localparam logic [TEMPO_W-1:0]  MIN_TEMPO_RESET  = 9'd1;
	localparam logic [TEMPO_W-1:0]  MAX_TEMPO_RESET  = 9'd300;
	localparam logic [PERIOD_W-1:0] ELAPSED_TOP      = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMPO = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMPO = 1'b1;

	// Divider produces one quotient bit per cycle.
	localparam int DIV_STEPS = PERIOD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage : btm_pkg
`default_nettype wire

// File: sv/btm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// btm_div: bit-serial divider for the beat period
// Restoring division of the fixed numerator by the tempo, one quotient bit
// per cycle through a shift register; the quotient is held until the next start.
// ---------------------------------------------------------------------------
module btm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire btm_pkg::div_ctl_t             ctl,
	input  wire logic [btm_pkg::TEMPO_W-1:0]   divisor,
	output btm_pkg::div_sts_t                  sts,
	output logic [btm_pkg::PERIOD_W-1:0]       quotient
);
	import btm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TEMPO_W-1:0]   div_q;
	logic [TEMPO_W-1:0]   rem_q;
	logic [PERIOD_W-1:0]  num_q;

	logic [TEMPO_W:0]     trial;
	logic [TEMPO_W+1:0]   diff;
	logic                 fits;

	// The remainder stays below the divisor, so the shifted remainder fits
	// one bit wider than the tempo.
	assign trial = {rem_q, num_q[PERIOD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign fits  = ~diff[TEMPO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits enter at the bottom as numerator bits leave at the top.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= divisor;
			rem_q <= '0;
			num_q <= PERIOD_NUMERATOR;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TEMPO_W-1:0] : trial[TEMPO_W-1:0];
			num_q <= {num_q[PERIOD_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = num_q;

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
	assert property (@(posedge clk) disable iff (!arst_n) ctl.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == '0 && !ctl.start |=> done_q)
		else $error("divider missed its done pulse");

endmodule : btm_div
`default_nettype wire

// File: sv/button_tempo_metronome_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// button_tempo_metronome_core: button-driven metronome tick generator
// Tracks button edges, tempo and elapsed milliseconds, emits beat ticks.
// ---------------------------------------------------------------------------
// The accepting edge updates the button edges, tempo and millisecond count
// and starts the bit-serial divider, which forms 60000 / tempo one quotient
// bit per cycle and flags completion with the last bit; the result is then
// compared and loaded into the output register as soon as that register is
// free. No new item is accepted until that load. The next item is accepted
// while the previous result still waits in the output register; a finished
// result waits only if that register is still full. An up edge raises the
// tempo only while it is below max_tempo and a down edge lowers it only while
// it is above min_tempo (0 acts as 1), and the elapsed count saturates at 65535.
module button_tempo_metronome_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [btm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [btm_pkg::CFG_W-1:0]         cfg_data,
	// input channel
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              enable_button,
	input  wire logic                              up_button,
	input  wire logic                              down_button,
	input  wire logic                              millisecond_passed,
	// output channel
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   tick,
	output logic                                   running,
	output logic [btm_pkg::TEMPO_W-1:0]            tempo,
	output logic [btm_pkg::PERIOD_W-1:0]           period_ms
);
	import btm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_WAIT
	} state_t;

	state_t              state_q;
	logic [TEMPO_W-1:0]  min_tempo_q;
	logic [TEMPO_W-1:0]  max_tempo_q;
	logic                enabled_q;
	logic                enable_prev_q;
	logic                up_prev_q;
	logic                down_prev_q;
	logic [TEMPO_W-1:0]  bpm_q;
	logic [PERIOD_W-1:0] elapsed_q;

	logic                out_valid_q;
	logic                tick_q;
	logic                running_q;
	logic [TEMPO_W-1:0]  tempo_q;
	logic [PERIOD_W-1:0] period_q;

	logic                in_accept;
	logic                out_free;
	logic                en_next;
	logic                up_edge;
	logic                down_edge;
	logic [TEMPO_W-1:0]  floor_tempo;
	logic [TEMPO_W-1:0]  bpm_up;
	logic [TEMPO_W-1:0]  bpm_next;
	logic [PERIOD_W-1:0] elapsed_next;
	logic                finish;
	logic                tick_now;

	div_ctl_t            div_ctl;
	div_sts_t            div_sts;
	logic [PERIOD_W-1:0] quotient;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Tempo update of one item: enable edge first, then up, then down.
	always_comb begin
		en_next      = enabled_q ^ (enable_button & ~enable_prev_q);
		up_edge      = en_next && up_button && !up_prev_q;
		down_edge    = en_next && down_button && !down_prev_q;
		floor_tempo  = (min_tempo_q == '0) ? MIN_TEMPO_RESET : min_tempo_q;
		bpm_up       = (up_edge && bpm_q < max_tempo_q) ? bpm_q + 1'b1 : bpm_q;
		bpm_next     = (down_edge && bpm_up > floor_tempo) ? bpm_up - 1'b1 : bpm_up;
		elapsed_next = (millisecond_passed && elapsed_q != ELAPSED_TOP)
			? elapsed_q + 1'b1 : elapsed_q;
	end

	assign div_ctl.start = in_accept;

	btm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.divisor  (bpm_next),
		.sts      (div_sts),
		.quotient (quotient)
	);

	assign finish   = ((state_q == ST_DIV && div_sts.done) || state_q == ST_WAIT) && out_free;
	assign tick_now = enabled_q && (elapsed_q > quotient);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_tempo_q   <= MIN_TEMPO_RESET;
			max_tempo_q   <= MAX_TEMPO_RESET;
			enabled_q     <= 1'b0;
			enable_prev_q <= 1'b0;
			up_prev_q     <= 1'b0;
			down_prev_q   <= 1'b0;
			bpm_q         <= TEMPO_RESET;
			elapsed_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_TEMPO: min_tempo_q <= cfg_data;
					REG_MAX_TEMPO: max_tempo_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						enabled_q     <= en_next;
						enable_prev_q <= enable_button;
						if (en_next) begin
							up_prev_q   <= up_button;
							down_prev_q <= down_button;
						end
						bpm_q     <= bpm_next;
						elapsed_q <= elapsed_next;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV, ST_WAIT: begin
					if (finish) begin
						out_valid_q <= 1'b1;
						if (tick_now) begin
							elapsed_q <= '0;
						end
						state_q <= ST_IDLE;
					end else if (state_q == ST_DIV && div_sts.done) begin
						state_q <= ST_WAIT;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			tick_q    <= tick_now;
			running_q <= enabled_q;
			tempo_q   <= bpm_q;
			period_q  <= quotient;
		end
	end

	assign out_valid = out_valid_q;
	assign tick      = tick_q;
	assign running   = running_q;
	assign tempo     = tempo_q;
	assign period_ms = period_q;

	assert property (@(posedge clk) disable iff (!arst_n) bpm_q != '0)
		else $error("tempo reached zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tick_q |-> running_q)
		else $error("tick emitted while stopped");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_sts.busy || div_sts.done)
		else $error("divide state without a running divider");

endmodule : button_tempo_metronome_core
`default_nettype wire

// File: tb/sv/metronome_beat_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// metronome_beat_checker: beat predictor and result comparator
// Mirrors tempo limit writes, computes the expected beat for every accepted
// item and compares each accepted result, field by field, in arrival order.
// ---------------------------------------------------------------------------
module metronome_beat_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [btm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [btm_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          enable_button,
	input  logic                          up_button,
	input  logic                          down_button,
	input  logic                          millisecond_passed,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          tick,
	input  logic                          running,
	input  logic [btm_pkg::TEMPO_W-1:0]   tempo,
	input  logic [btm_pkg::PERIOD_W-1:0]  period_ms,
	output int                            fail_count,
	output int                            beats_pending
);
	import btm_pkg::*;

	localparam logic [TEMPO_W-1:0] BPM_ONE = 1;

	typedef struct packed {
		logic                tick;
		logic                running;
		logic [TEMPO_W-1:0]  tempo;
		logic [PERIOD_W-1:0] period;
	} beat_t;

	logic [TEMPO_W-1:0]  lim_min   = MIN_TEMPO_RESET;
	logic [TEMPO_W-1:0]  lim_max   = MAX_TEMPO_RESET;
	logic                on_q      = 1'b0;
	logic                en_seen   = 1'b0;
	logic                up_seen   = 1'b0;
	logic                dn_seen   = 1'b0;
	logic [TEMPO_W-1:0]  bpm_q     = TEMPO_RESET;
	logic [PERIOD_W-1:0] elapsed_q = '0;
	beat_t               beat_q[$];

	initial begin
		fail_count    = 0;
		beats_pending = 0;
	end

	// Advances the metronome state by one sample and returns the beat it yields.
	function automatic beat_t next_beat(input logic en, input logic up, input logic dn,
			input logic ms);
		logic [TEMPO_W-1:0]  floor_bpm;
		logic [PERIOD_W-1:0] beat_len;
		beat_t               b;
		floor_bpm = (lim_min == '0) ? BPM_ONE : lim_min;
		if (en && !en_seen) begin
			on_q = !on_q;
		end
		en_seen = en;
		// The up and down edge memory is frozen while the metronome is off.
		if (on_q) begin
			if (up && !up_seen && bpm_q < lim_max) begin
				bpm_q = bpm_q + 1'b1;
			end
			up_seen = up;
			if (dn && !dn_seen && bpm_q > floor_bpm) begin
				bpm_q = bpm_q - 1'b1;
			end
			dn_seen = dn;
		end
		beat_len = PERIOD_NUMERATOR / {{(PERIOD_W-TEMPO_W){1'b0}}, bpm_q};
		if (ms && elapsed_q != ELAPSED_TOP) begin
			elapsed_q = elapsed_q + 1'b1;
		end
		b.tick = 1'b0;
		if (elapsed_q > beat_len && on_q) begin
			b.tick    = 1'b1;
			elapsed_q = '0;
		end
		b.running = on_q;
		b.tempo   = bpm_q;
		b.period  = beat_len;
		return b;
	endfunction

	task automatic report_beat(input string what, input beat_t want, input beat_t seen);
		fail_count++;
		if (fail_count <= 10) begin
			$display("[%0t] %s: expected tick=%0b running=%0b tempo=%0d period=%0d",
				$realtime, what, want.tick, want.running, want.tempo, want.period);
			$display("        got tick=%0b running=%0b tempo=%0d period=%0d",
				seen.tick, seen.running, seen.tempo, seen.period);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		beat_t seen;
		beat_t want;
		if (!arst_n) begin
			lim_min   = MIN_TEMPO_RESET;
			lim_max   = MAX_TEMPO_RESET;
			on_q      = 1'b0;
			en_seen   = 1'b0;
			up_seen   = 1'b0;
			dn_seen   = 1'b0;
			bpm_q     = TEMPO_RESET;
			elapsed_q = '0;
			beat_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_TEMPO: lim_min = cfg_data;
					REG_MAX_TEMPO: lim_max = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen = {tick, running, tempo, period_ms};
				if (beat_q.size() == 0) begin
					report_beat("result with nothing expected", '0, seen);
				end else begin
					want = beat_q.pop_front();
					if (seen.tick !== want.tick || seen.running !== want.running ||
							seen.tempo !== want.tempo || seen.period !== want.period) begin
						report_beat("beat mismatch", want, seen);
					end
				end
			end
			if (in_valid && !in_stall) begin
				beat_q.push_back(next_beat(enable_button, up_button, down_button,
					millisecond_passed));
			end
		end
		beats_pending = beat_q.size();
	end

endmodule

// File: tb/sv/tb_button_tempo_metronome_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_button_tempo_metronome_core: testbench of the metronome core
// Drives button samples through the core under several tempo limit settings,
// with random gaps, output stalls and one long output hold-off, and lets a
// checker compare every beat against its own prediction.
// ---------------------------------------------------------------------------
module tb_button_tempo_metronome_core;
	import btm_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int CYCLE_LIMIT    = 400_000;
	localparam int OFF_ITEMS      = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 enable_button;
	logic                 up_button;
	logic                 down_button;
	logic                 millisecond_passed;
	logic                 out_valid;
	logic                 out_stall;
	logic                 tick;
	logic                 running;
	logic [TEMPO_W-1:0]   tempo;
	logic [PERIOD_W-1:0]  period_ms;

	int fail_count;
	int beats_pending;
	int cycle_cnt;
	bit gaps_on;
	bit stalls_on;
	bit hold_req;
	// Our own view of the on/off toggle, used only to steer the stimulus.
	bit btn_level;
	bit mirror_on;

	button_tempo_metronome_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.enable_button      (enable_button),
		.up_button          (up_button),
		.down_button        (down_button),
		.millisecond_passed (millisecond_passed),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.tick               (tick),
		.running            (running),
		.tempo              (tempo),
		.period_ms          (period_ms)
	);

	metronome_beat_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.enable_button      (enable_button),
		.up_button          (up_button),
		.down_button        (down_button),
		.millisecond_passed (millisecond_passed),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.tick               (tick),
		.running            (running),
		.tempo              (tempo),
		.period_ms          (period_ms),
		.fail_count         (fail_count),
		.beats_pending      (beats_pending)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic logic ms_draw();
		return $urandom_range(99) < 90;
	endfunction

	// Offers one item and returns at the falling edge after it was accepted,
	// leaving valid high so the next item can follow without a gap.
	task automatic send_sample(input logic en, input logic up, input logic dn,
			input logic ms);
		while (gaps_on && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid           <= 1'b1;
		enable_button      <= en;
		up_button          <= up;
		down_button        <= dn;
		millisecond_passed <= ms;
		if (en && !btn_level) begin
			mirror_on = !mirror_on;
		end
		btn_level = en;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		in_valid <= 1'b0;
		wait (beats_pending == 0);
		@(negedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_TEMPO;
		cfg_data  <= lo;
		@(negedge clk);
		cfg_index <= REG_MAX_TEMPO;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly press-and-release pairs on up or down with the metronome kept
	// running, mixed with enable toggles and fully random samples.
	task automatic run_mix(input int n, input int up_pct, input int noise_pct);
		int   sent;
		logic go_up;
		sent = 0;
		while (sent < n) begin
			if (!mirror_on || $urandom_range(99) < 3) begin
				send_sample(1'b1, 1'b0, 1'b0, ms_draw());
				send_sample(1'b0, 1'b0, 1'b0, ms_draw());
				sent += 2;
			end else if ($urandom_range(99) < noise_pct) begin
				send_sample($urandom_range(1), $urandom_range(1), $urandom_range(1),
					$urandom_range(1));
				sent += 1;
			end else begin
				go_up = $urandom_range(99) < up_pct;
				send_sample(1'b0, go_up, !go_up, ms_draw());
				send_sample(1'b0, 1'b0, 1'b0, ms_draw());
				sent += 2;
			end
		end
	endtask

	// Output side: random stalls, or one long hold-off when asked for.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= stalls_on && ($urandom_range(99) < 30);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = REG_MIN_TEMPO;
		cfg_data           = '0;
		in_valid           = 1'b0;
		enable_button      = 1'b0;
		up_button          = 1'b0;
		down_button        = 1'b0;
		millisecond_passed = 1'b0;
		gaps_on            = 1'b0;
		stalls_on          = 1'b0;
		hold_req           = 1'b0;
		btn_level          = 1'b0;
		mirror_on          = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		set_limits(MIN_TEMPO_RESET, MAX_TEMPO_RESET);

		// Up and down are ignored while off, so the first enabled sample with
		// up held still sees a rising edge.
		send_sample(1'b0, 1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b1, 1'b1, 1'b1);
		send_sample(1'b1, 1'b1, 1'b0, 1'b1);
		send_sample(1'b1, 1'b1, 1'b0, 1'b1);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1);
		send_sample(1'b0, 1'b1, 1'b1, 1'b0);
		send_sample(1'b0, 1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b1, 1'b1, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0, 1'b0);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0, 1'b1);
		send_sample(1'b1, 1'b1, 1'b1, 1'b1);
		send_sample(1'b0, 1'b0, 1'b0, 1'b0);
		// The tempo now sits at 121: pin it against each limit in turn.
		set_limits(MIN_TEMPO_RESET, 121);
		send_sample(1'b0, 1'b1, 1'b0, 1'b1);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		set_limits(121, 121);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);

		// Walk the tempo down onto a zero minimum, which must act as one.
		set_limits(0, 511);
		run_mix(300, 0, 5);

		// Switched off, the millisecond count keeps running; switching on
		// then tests the stored count against the period right away.
		if (mirror_on) begin
			send_sample(1'b1, 1'b0, 1'b0, 1'b1);
			send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		end
		repeat (OFF_ITEMS) send_sample(1'b0, 1'b0, 1'b0, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0, 1'b1);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1);

		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		set_limits(1, 511);
		run_mix(850, 100, 3);

		// Minimum above maximum, with the output held off for a long stretch.
		set_limits(300, 200);
		hold_req = 1'b1;
		run_mix(120, 50, 10);
		set_limits(511, 1);
		run_mix(80, 50, 10);
		set_limits(MIN_TEMPO_RESET, MAX_TEMPO_RESET);
		run_mix(120, 50, 20);

		in_valid <= 1'b0;
		wait (beats_pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && beats_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
